@@ rtl/core/minimizer_superkmer_splitter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the minimizer super-k-mer splitter
// Shared forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef MINIMIZER_SUPERKMER_SPLITTER_DEFINES_SVH
`define MINIMIZER_SUPERKMER_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSS_ASSERT_HOLD(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss: same-cycle check failed");

// Next-cycle implication that also holds across reset.
`define MSS_ASSERT_AFTER(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mss: next-cycle check failed");

`endif

@@ rtl/core/mss_pkg.sv @@
// ----------------------------------------------------------------------------
// mss_pkg
// Types and constants shared by the super-k-mer splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

    localparam int HASH_W   = 64;
    localparam int START_W  = 32;
    localparam int BASES_W  = 8;
    localparam int BUCKET_W = 4;
    localparam int SLOT_W   = 16;
    localparam int CFG_W    = 16;
    localparam int MOD_STEP = 4;
    localparam int MOD_CYC  = HASH_W / MOD_STEP;

    typedef enum logic [1:0] {
        CFG_KMER_LEN = 2'd0,
        CFG_MIN_LEN  = 2'd1,
        CFG_BKT_CNT  = 2'd2,
        CFG_SLOTS    = 2'd3
    } t_cfg_idx;

    // Queued item, already classified by strand.
    typedef struct packed {
        logic [HASH_W-1:0] fwd;
        logic [HASH_W-1:0] rev;
        logic              eos;
        logic [HASH_W-1:0] cand;
        logic              cand_rev;
    } t_item;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [BASES_W-1:0]  bases;
        logic                rev;
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
        logic [HASH_W-1:0]   min_hash;
        logic                final_seq;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/mss_item_if.sv @@
// ----------------------------------------------------------------------------
// mss_item_if
// Input channel: one m-mer hash pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_item_if;
    logic                        valid;
    logic                        ready;
    logic [mss_pkg::HASH_W-1:0]  fwd_hash;
    logic [mss_pkg::HASH_W-1:0]  rev_hash;
    logic                        end_of_sequence;

    modport source(output valid, fwd_hash, rev_hash, end_of_sequence, input ready);
    modport sink(input valid, fwd_hash, rev_hash, end_of_sequence, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mss_skmer_if.sv @@
// ----------------------------------------------------------------------------
// mss_skmer_if
// Output channel: one closed super-k-mer per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface mss_skmer_if;
    logic                          valid;
    logic                          ready;
    logic [mss_pkg::START_W-1:0]   skmer_start;
    logic [mss_pkg::BASES_W-1:0]   skmer_bases;
    logic                          reverse_strand;
    logic [mss_pkg::BUCKET_W-1:0]  bucket;
    logic [mss_pkg::SLOT_W-1:0]    slot;
    logic [mss_pkg::HASH_W-1:0]    minimizer_hash;
    logic                          final_of_sequence;

    modport source(output valid, skmer_start, skmer_bases, reverse_strand, bucket, slot,
                   minimizer_hash, final_of_sequence, input ready);
    modport sink(input valid, skmer_start, skmer_bases, reverse_strand, bucket, slot,
                 minimizer_hash, final_of_sequence, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mss_front.sv @@
// ----------------------------------------------------------------------------
// mss_front
// Accepts input items, picks the smaller strand hash and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mss_item_if.sink           i_item,
    output mss_pkg::t_item     o_q_item,
    output logic               o_q_valid,
    input  wire logic          i_q_pop
);

    mss_pkg::t_item r_q_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;
    mss_pkg::t_item w_new;

    assign i_item.ready = (r_count != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = i_q_pop && (r_count != 2'd0);
    assign o_q_valid    = (r_count != 2'd0);
    assign o_q_item     = r_q_mem[r_rd_ptr];

    // Forward wins a tie between the two strands.
    always_comb begin
        w_new.fwd = i_item.fwd_hash;
        w_new.rev = i_item.rev_hash;
        w_new.eos = i_item.end_of_sequence;
        if (i_item.rev_hash < i_item.fwd_hash) begin
            w_new.cand     = i_item.rev_hash;
            w_new.cand_rev = 1'b1;
        end else begin
            w_new.cand     = i_item.fwd_hash;
            w_new.cand_rev = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/mss_back.sv @@
// ----------------------------------------------------------------------------
// mss_back
// Window store, minimizer tracking, rescans and super-k-mer emission.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back #(
    parameter int WINDOW_MAX = 64,
    parameter int BUCKET_MAX = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [6:0]                       i_kmer_len,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]  i_win,
    input  wire logic [$clog2(BUCKET_MAX+1)-1:0]  i_q_eff,
    input  wire logic [mss_pkg::SLOT_W-1:0]       i_depth,
    input  wire logic                             i_q_valid,
    input  mss_pkg::t_item                        i_q_item,
    output logic                                  o_q_pop,
    mss_skmer_if.source                           o_skmer
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WW = $clog2(WINDOW_MAX+1);
    localparam int QW = $clog2(BUCKET_MAX+1);
    localparam int BW = (BUCKET_MAX > 1) ? $clog2(BUCKET_MAX) : 1;
    localparam int HW = mss_pkg::HASH_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WR, ST_SCINIT, ST_SCAN, ST_SCLAST, ST_POST, ST_CLR, ST_MOD, ST_OUT
    } t_state;

    logic [2*HW-1:0]          r_win_mem [WINDOW_MAX];
    logic [2*HW-1:0]          r_rd_data;

    t_state                   r_state;
    t_state                   r_ret;
    mss_pkg::t_item           r_it;
    logic [AW-1:0]            r_wp;
    logic [WW-1:0]            r_fill;
    logic [AW-1:0]            r_min_pos;
    logic [HW-1:0]            r_min_val;
    logic                     r_min_rev;
    logic [31:0]              r_kidx;
    logic [31:0]              r_open_start;
    logic [7:0]               r_open_bases;
    logic                     r_open_rev;
    logic                     r_made;
    logic [AW-1:0]            r_idx;
    logic [AW-1:0]            r_sc_addr;
    logic [WW-1:0]            r_sc_cnt;
    logic [AW-1:0]            r_rd_pos;
    logic                     r_rd_vld;
    logic                     r_have;
    mss_pkg::t_result         r_rec;
    logic [HW-1:0]            r_mod_sh;
    logic [QW-1:0]            r_mod_rem;
    logic [3:0]               r_mod_cnt;
    logic [mss_pkg::SLOT_W-1:0] r_slot [BUCKET_MAX];
    mss_pkg::t_result         r_out;
    logic                     r_out_vld;

    logic [AW-1:0]            w_idx;
    logic [AW-1:0]            w_next_idx;
    logic [AW-1:0]            w_sc_next;
    logic [HW-1:0]            w_rd_v;
    logic                     w_rd_r;
    logic                     w_take;
    logic [QW-1:0]            n_mod_rem;
    logic [BW-1:0]            w_bkt;
    logic [mss_pkg::SLOT_W-1:0] w_slot;
    logic [mss_pkg::SLOT_W:0]   w_slot_p1;
    logic                     w_out_free;
    logic                     w_out_load;
    mss_pkg::t_result         w_out_rec;

    assign w_idx      = (WW'(r_wp) >= i_win) ? AW'(0) : r_wp;
    assign w_next_idx = ((WW'(r_idx) + WW'(1)) == i_win) ? AW'(0) : r_idx + AW'(1);
    assign w_sc_next  = ((WW'(r_sc_addr) + WW'(1)) == i_win) ? AW'(0) : r_sc_addr + AW'(1);

    assign w_rd_r = (r_rd_data[HW-1:0] < r_rd_data[2*HW-1:HW]);
    assign w_rd_v = w_rd_r ? r_rd_data[HW-1:0] : r_rd_data[2*HW-1:HW];
    assign w_take = !r_have || (w_rd_v < r_min_val);

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;

    // Four restoring steps of the bucket remainder per cycle, top bits first.
    always_comb begin
        logic [QW:0] rem2;
        n_mod_rem = r_mod_rem;
        for (int i = 0; i < mss_pkg::MOD_STEP; i++) begin
            rem2 = {n_mod_rem, r_mod_sh[HW-1-i]};
            if (rem2 >= {1'b0, i_q_eff}) begin
                rem2 = rem2 - {1'b0, i_q_eff};
            end
            n_mod_rem = rem2[QW-1:0];
        end
    end

    assign w_bkt      = r_mod_rem[BW-1:0];
    assign w_slot     = (r_slot[w_bkt] >= i_depth) ? '0 : r_slot[w_bkt];
    assign w_slot_p1  = {1'b0, w_slot} + 17'd1;
    assign w_out_free = !r_out_vld || o_skmer.ready;
    assign w_out_load = (r_state == ST_OUT) && w_out_free;

    always_comb begin
        w_out_rec        = r_rec;
        w_out_rec.bucket = mss_pkg::BUCKET_W'(r_mod_rem);
        w_out_rec.slot   = w_slot;
    end

    assign o_skmer.valid             = r_out_vld;
    assign o_skmer.skmer_start       = r_out.start;
    assign o_skmer.skmer_bases       = r_out.bases;
    assign o_skmer.reverse_strand    = r_out.rev;
    assign o_skmer.bucket            = r_out.bucket;
    assign o_skmer.slot              = r_out.slot;
    assign o_skmer.minimizer_hash    = r_out.min_hash;
    assign o_skmer.final_of_sequence = r_out.final_seq;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR) begin
            r_win_mem[w_idx] <= {r_it.fwd, r_it.rev};
        end
        if (r_state == ST_SCAN) begin
            r_rd_data <= r_win_mem[r_sc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_wp         <= '0;
            r_fill       <= '0;
            r_min_pos    <= '0;
            r_min_val    <= '0;
            r_min_rev    <= 1'b0;
            r_kidx       <= '0;
            r_open_start <= '0;
            r_open_bases <= '0;
            r_open_rev   <= 1'b0;
            r_made       <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_have       <= 1'b0;
            r_out_vld    <= 1'b0;
            for (int b = 0; b < BUCKET_MAX; b++) begin
                r_slot[b] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_skmer.ready) begin
                r_out_vld <= 1'b0;
            end
            if (r_rd_vld && w_take) begin
                r_min_val <= w_rd_v;
                r_min_pos <= r_rd_pos;
                r_min_rev <= w_rd_r;
                r_have    <= 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_it    <= i_q_item;
                        r_state <= ST_WR;
                    end
                end
                ST_WR: begin
                    r_idx         <= w_idx;
                    r_rec.start   <= r_open_start;
                    r_rec.bases   <= r_open_bases;
                    r_rec.rev     <= r_open_rev;
                    r_rec.bucket  <= '0;
                    r_rec.slot    <= '0;
                    r_rec.min_hash <= r_min_val;
                    r_rec.final_seq <= 1'b0;
                    r_mod_sh      <= r_min_val;
                    r_mod_rem     <= '0;
                    r_mod_cnt     <= '0;
                    if (r_fill < i_win) begin
                        r_fill <= r_fill + WW'(1);
                        if ((r_fill + WW'(1)) >= i_win) begin
                            r_made  <= 1'b1;
                            r_state <= ST_SCINIT;
                        end else begin
                            r_made  <= 1'b0;
                            r_state <= ST_POST;
                        end
                    end else begin
                        r_made <= 1'b1;
                        if (r_min_pos == w_idx || WW'(r_min_pos) >= i_win) begin
                            // The minimizer falls out: close, then rescan.
                            r_ret   <= ST_SCINIT;
                            r_state <= ST_MOD;
                        end else if (r_it.cand < r_min_val) begin
                            r_min_val    <= r_it.cand;
                            r_min_pos    <= w_idx;
                            r_min_rev    <= r_it.cand_rev;
                            r_open_start <= r_kidx;
                            r_open_bases <= {1'b0, i_kmer_len};
                            r_open_rev   <= r_it.cand_rev;
                            r_ret        <= ST_POST;
                            r_state      <= ST_MOD;
                        end else begin
                            if (r_open_bases != 8'hFF) begin
                                r_open_bases <= r_open_bases + 8'd1;
                            end
                            r_state <= ST_POST;
                        end
                    end
                end
                ST_SCINIT: begin
                    r_sc_addr <= w_next_idx;
                    r_sc_cnt  <= '0;
                    r_have    <= 1'b0;
                    r_rd_vld  <= 1'b0;
                    r_state   <= ST_SCAN;
                end
                ST_SCAN: begin
                    r_rd_vld  <= 1'b1;
                    r_rd_pos  <= r_sc_addr;
                    r_sc_addr <= w_sc_next;
                    r_sc_cnt  <= r_sc_cnt + WW'(1);
                    if ((r_sc_cnt + WW'(1)) == i_win) begin
                        r_state <= ST_SCLAST;
                    end
                end
                ST_SCLAST: begin
                    // The last entry is compared in this cycle.
                    r_rd_vld     <= 1'b0;
                    r_open_start <= r_kidx;
                    r_open_bases <= {1'b0, i_kmer_len};
                    r_open_rev   <= w_take ? w_rd_r : r_min_rev;
                    r_state      <= ST_POST;
                end
                ST_POST: begin
                    if (r_made && r_kidx != 32'hFFFF_FFFF) begin
                        r_kidx <= r_kidx + 32'd1;
                    end
                    r_wp <= w_next_idx;
                    r_rec.start     <= r_open_start;
                    r_rec.bases     <= r_open_bases;
                    r_rec.rev       <= r_open_rev;
                    r_rec.bucket    <= '0;
                    r_rec.slot      <= '0;
                    r_rec.min_hash  <= r_min_val;
                    r_rec.final_seq <= 1'b1;
                    r_mod_sh        <= r_min_val;
                    r_mod_rem       <= '0;
                    r_mod_cnt       <= '0;
                    if (r_it.eos) begin
                        if (r_fill >= i_win) begin
                            r_ret   <= ST_CLR;
                            r_state <= ST_MOD;
                        end else begin
                            r_state <= ST_CLR;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_CLR: begin
                    r_wp         <= '0;
                    r_fill       <= '0;
                    r_min_pos    <= '0;
                    r_min_val    <= '0;
                    r_min_rev    <= 1'b0;
                    r_kidx       <= '0;
                    r_open_start <= '0;
                    r_open_bases <= '0;
                    r_open_rev   <= 1'b0;
                    r_state      <= ST_IDLE;
                end
                ST_MOD: begin
                    r_mod_rem <= n_mod_rem;
                    r_mod_sh  <= r_mod_sh << mss_pkg::MOD_STEP;
                    r_mod_cnt <= r_mod_cnt + 4'd1;
                    if (r_mod_cnt == 4'(mss_pkg::MOD_CYC - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_slot[w_bkt] <= (w_slot_p1 >= {1'b0, i_depth}) ? '0
                                         : w_slot_p1[mss_pkg::SLOT_W-1:0];
                        r_out         <= w_out_rec;
                        r_state       <= r_ret;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/minimizer_superkmer_splitter.sv @@
// ----------------------------------------------------------------------------
// minimizer_superkmer_splitter
// Splits a stream of m-mer hash pairs into super-k-mers routed by minimizer.
// ----------------------------------------------------------------------------
// Each item is the forward and reverse hash of one m-mer; a two-entry queue
// decouples the input from the processing engine. An item that closes
// nothing passes the engine states IDLE, WR and POST. Closing a super-k-mer
// adds the four-bit-per-cycle bucket remainder unit (MOD) and the output
// load (OUT, which waits while the output register is full), and a rescan,
// when the minimizer leaves the window or the window first fills, adds SCINIT,
// one window memory read per entry (w = k-m+1 capped at WINDOW_MAX) and SCLAST.
// The end of a sequence adds the CLR state, plus an emission if a super-k-mer is open.
`default_nettype none

`include "minimizer_superkmer_splitter_defines.svh"

module minimizer_superkmer_splitter #(
    parameter int WINDOW_MAX = 64,
    parameter int BUCKET_MAX = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [mss_pkg::CFG_W-1:0]  i_cfg_data,
    mss_item_if.sink                        i_item,
    mss_skmer_if.source                     o_skmer
);

    localparam int WW = $clog2(WINDOW_MAX+1);
    localparam int QW = $clog2(BUCKET_MAX+1);

    logic [6:0]                  r_kmer_len;
    logic [6:0]                  r_min_len;
    logic [4:0]                  r_bkt_cnt;
    logic [mss_pkg::SLOT_W-1:0]  r_slots;

    logic [8:0]                  w_win_raw;
    logic [WW-1:0]               w_win;
    logic [QW-1:0]               w_q_eff;
    logic [mss_pkg::SLOT_W-1:0]  w_depth;
    mss_pkg::t_item              w_q_item;
    logic                        w_q_valid;
    logic                        w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= 7'd31;
            r_min_len  <= 7'd15;
            r_bkt_cnt  <= 5'd4;
            r_slots    <= 16'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mss_pkg::CFG_KMER_LEN: r_kmer_len <= i_cfg_data[6:0];
                mss_pkg::CFG_MIN_LEN:  r_min_len  <= i_cfg_data[6:0];
                mss_pkg::CFG_BKT_CNT:  r_bkt_cnt  <= i_cfg_data[4:0];
                mss_pkg::CFG_SLOTS:    r_slots    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_win_raw = 9'd1;
        if (r_min_len < r_kmer_len) begin
            w_win_raw = {2'b00, r_kmer_len} - {2'b00, r_min_len} + 9'd1;
        end
        if (w_win_raw > 9'(WINDOW_MAX)) begin
            w_win_raw = 9'(WINDOW_MAX);
        end
        w_win = WW'(w_win_raw);

        if (r_bkt_cnt == 5'd0) begin
            w_q_eff = QW'(1);
        end else if ({2'b00, r_bkt_cnt} > 7'(BUCKET_MAX)) begin
            w_q_eff = QW'(BUCKET_MAX);
        end else begin
            w_q_eff = QW'(r_bkt_cnt);
        end

        w_depth = (r_slots == '0) ? 16'd1 : r_slots;
    end

    mss_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_q_item  (w_q_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop)
    );

    mss_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .BUCKET_MAX (BUCKET_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_kmer_len (r_kmer_len),
        .i_win      (w_win),
        .i_q_eff    (w_q_eff),
        .i_depth    (w_depth),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_skmer    (o_skmer)
    );

    // The engine pops only an item that the queue holds.
    `MSS_ASSERT_HOLD(a_pop_has_item, i_clk, i_rst_n, w_q_pop, w_q_valid)
    // A refused input means the queue has an item waiting for the engine.
    `MSS_ASSERT_HOLD(a_full_has_item, i_clk, i_rst_n, !i_item.ready, w_q_valid)
    `MSS_ASSERT_AFTER(a_rst_no_out, i_clk, !i_rst_n, !o_skmer.valid)

endmodule

`default_nettype wire
